### src/kla_pkg.sv
package kla_pkg;

    localparam int NCOMP       = 10;
    localparam int COMP_W      = 32;
    localparam int TIME_W      = 24;
    localparam int COMP_IDX_W  = 4;
    localparam int MUL_A_W     = 18;
    localparam int MUL_B_W     = 28;
    localparam int MUL_P_W     = MUL_A_W + MUL_B_W;
    localparam int ACC_W       = 64;
    localparam int HALF_W      = 16;

    localparam logic [COMP_IDX_W-1:0] ROT_FIRST = 4'd3;
    localparam logic [COMP_IDX_W-1:0] ROT_LAST  = 4'd5;

    // round(pi/180 * 2^32)
    localparam logic [26:0] DEG2RAD_Q32 = 27'd74961321;

    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_TICK  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_RSVD  = 2'd3
    } cmd_t;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [23:0]        time_value;
        logic signed [31:0] move_x;
        logic signed [31:0] move_y;
        logic signed [31:0] move_z;
        logic signed [31:0] turn_x_deg;
        logic signed [31:0] turn_y_deg;
        logic signed [31:0] turn_z_deg;
        logic signed [31:0] size_x;
        logic signed [31:0] size_y;
        logic signed [31:0] size_z;
        logic signed [31:0] opacity;
    } in_item_t;

    typedef struct packed {
        logic               finished;
        logic signed [31:0] out_move_x;
        logic signed [31:0] out_move_y;
        logic signed [31:0] out_move_z;
        logic signed [31:0] out_turn_x;
        logic signed [31:0] out_turn_y;
        logic signed [31:0] out_turn_z;
        logic signed [31:0] out_size_x;
        logic signed [31:0] out_size_y;
        logic signed [31:0] out_size_z;
        logic signed [31:0] out_opacity;
    } out_item_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_ADD_COMP,
        ST_ADD_MHI,
        ST_ADD_WR,
        ST_SRCH_RD,
        ST_SRCH_CHK,
        ST_PREV_RD,
        ST_PREV_CHK,
        ST_DIV,
        ST_LR_RDA,
        ST_LR_RDB,
        ST_LR_DIF,
        ST_LR_MLO,
        ST_LR_MHI,
        ST_LR_WR,
        ST_CP_RD,
        ST_CP_WR,
        ST_OUT
    } state_t;

endpackage

### src/kla_req_if.sv
interface kla_req_if;
    logic               valid;
    logic               ready;
    kla_pkg::in_item_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### src/kla_rsp_if.sv
interface kla_rsp_if;
    logic               valid;
    logic               ready;
    kla_pkg::out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### src/keyframe_lerp_animator.sv
// Add stores one key, ignored when the table is full; clear empties the key table and zeroes elapsed time.
// Tick: after the accepting cycle, a search over the keys, then a copy of the key's components or
// a serial divide and a lerp of each component,
// then a load of the result register; it waits while the last result is unread.
// One item at a time; the shared 18x28 multiplier and the serial divider set the rate.
// Reset: key table empty, elapsed time zero, current frame zero, no result pending.
module keyframe_lerp_animator #(
    parameter int MAX_KEYS  = 16,
    parameter int FRAC_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    kla_req_if.sink     req,
    kla_rsp_if.source   rsp
);

    localparam int KW     = $clog2(MAX_KEYS);
    localparam int CW     = $clog2(MAX_KEYS + 1);
    localparam int QW     = FRAC_BITS + 1;
    localparam int CI_W   = kla_pkg::COMP_IDX_W;
    localparam int CA_W   = KW + CI_W;
    localparam int TW     = kla_pkg::TIME_W;
    localparam int ACC_W  = kla_pkg::ACC_W;
    localparam int NCOMP  = kla_pkg::NCOMP;
    localparam int HALF_W = kla_pkg::HALF_W;

    kla_pkg::state_t            state_reg, state_next;
    kla_pkg::in_item_t          item_reg;
    kla_pkg::out_item_t         out_reg;
    logic                       out_valid_reg;
    logic [CW-1:0]              key_count_reg;
    logic [TW-1:0]              elapsed_reg;
    logic signed [31:0]         frame_reg [NCOMP];
    logic [CI_W-1:0]            comp_idx_reg;
    logic [KW-1:0]              key_idx_reg;
    logic [TW-1:0]              key_time_reg;
    logic                       finish_reg;
    logic [QW-1:0]              t_reg;
    logic signed [31:0]         a_reg;
    logic signed [32:0]         d_reg;
    logic signed [ACC_W-1:0]    acc_reg;

    logic [TW-1:0]              time_mem [MAX_KEYS];
    logic [31:0]                comp_mem [MAX_KEYS * (2 ** CI_W)];
    logic [TW-1:0]              time_rd_reg;
    logic signed [31:0]         comp_rd_reg;

    logic [KW-1:0]              time_rd_addr;
    logic                       time_wr_en;
    logic [CA_W-1:0]            comp_rd_addr;
    logic [CA_W-1:0]            comp_wr_addr;
    logic                       comp_wr_en;
    logic [31:0]                comp_wr_data;

    logic signed [kla_pkg::MUL_A_W-1:0] mul_a;
    logic signed [kla_pkg::MUL_B_W-1:0] mul_b;
    logic signed [kla_pkg::MUL_P_W-1:0] product;

    logic signed [31:0]         item_comp [NCOMP];
    logic                       accept;
    logic                       is_rot;
    logic                       comp_last;
    logic                       idx_last;
    logic                       key_match;
    logic                       out_free;
    logic [KW-1:0]              prev_idx;
    logic signed [ACC_W-1:0]    acc_round;
    logic signed [ACC_W-1:0]    acc_sh;
    logic signed [31:0]         lerp_val;
    logic [TW:0]                elapsed_sum;
    logic [TW-1:0]              elapsed_sat;
    logic                       div_start;
    logic [TW-1:0]              div_diff;
    logic [TW-1:0]              div_span;
    kla_pkg::div_stat_t         div_stat;
    logic [QW-1:0]              div_quot;

    kla_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .diff  (div_diff),
        .span  (div_span),
        .stat  (div_stat),
        .quot  (div_quot)
    );

    always_comb
    begin
        item_comp[0] = item_reg.move_x;
        item_comp[1] = item_reg.move_y;
        item_comp[2] = item_reg.move_z;
        item_comp[3] = item_reg.turn_x_deg;
        item_comp[4] = item_reg.turn_y_deg;
        item_comp[5] = item_reg.turn_z_deg;
        item_comp[6] = item_reg.size_x;
        item_comp[7] = item_reg.size_y;
        item_comp[8] = item_reg.size_z;
        item_comp[9] = item_reg.opacity;
    end

    assign accept    = req.valid && req.ready;
    assign is_rot    = (comp_idx_reg >= kla_pkg::ROT_FIRST) && (comp_idx_reg <= kla_pkg::ROT_LAST);
    assign comp_last = comp_idx_reg == CI_W'(NCOMP - 1);
    assign idx_last  = (CW'(key_idx_reg) + CW'(1)) == key_count_reg;
    assign key_match = elapsed_reg <= time_rd_reg;
    assign out_free  = !out_valid_reg || rsp.ready;
    assign prev_idx  = key_idx_reg - KW'(1);
    assign product   = mul_a * mul_b;
    assign acc_round = acc_reg + ACC_W'(64'sh8000_0000);
    assign acc_sh    = acc_reg >>> FRAC_BITS;
    assign lerp_val  = a_reg + acc_sh[31:0];
    assign elapsed_sum = {1'b0, elapsed_reg} + {1'b0, item_reg.time_value};
    assign elapsed_sat = elapsed_sum[TW] ? {TW{1'b1}} : elapsed_sum[TW-1:0];
    assign div_diff  = elapsed_reg - time_rd_reg;
    assign div_span  = key_time_reg - time_rd_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            kla_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (kla_pkg::cmd_t'(req.data.cmd))
                        kla_pkg::CMD_ADD:
                            if (key_count_reg < CW'(MAX_KEYS))
                                state_next = kla_pkg::ST_ADD_COMP;
                        kla_pkg::CMD_TICK:
                            state_next = (key_count_reg == '0) ? kla_pkg::ST_OUT
                                                               : kla_pkg::ST_SRCH_RD;
                        default:
                            state_next = kla_pkg::ST_IDLE;
                    endcase
                end
            end
            kla_pkg::ST_ADD_COMP:
            begin
                if (is_rot)
                    state_next = kla_pkg::ST_ADD_MHI;
                else if (comp_last)
                    state_next = kla_pkg::ST_IDLE;
            end
            kla_pkg::ST_ADD_MHI:
                state_next = kla_pkg::ST_ADD_WR;
            kla_pkg::ST_ADD_WR:
                state_next = comp_last ? kla_pkg::ST_IDLE : kla_pkg::ST_ADD_COMP;
            kla_pkg::ST_SRCH_RD:
                state_next = kla_pkg::ST_SRCH_CHK;
            kla_pkg::ST_SRCH_CHK:
            begin
                if (key_match)
                    state_next = (key_idx_reg == '0) ? kla_pkg::ST_CP_RD : kla_pkg::ST_PREV_RD;
                else if (idx_last)
                    state_next = kla_pkg::ST_CP_RD;
                else
                    state_next = kla_pkg::ST_SRCH_RD;
            end
            kla_pkg::ST_PREV_RD:
                state_next = kla_pkg::ST_PREV_CHK;
            kla_pkg::ST_PREV_CHK:
                state_next = kla_pkg::ST_DIV;
            kla_pkg::ST_DIV:
                if (div_stat.done)
                    state_next = kla_pkg::ST_LR_RDA;
            kla_pkg::ST_LR_RDA:
                state_next = kla_pkg::ST_LR_RDB;
            kla_pkg::ST_LR_RDB:
                state_next = kla_pkg::ST_LR_DIF;
            kla_pkg::ST_LR_DIF:
                state_next = kla_pkg::ST_LR_MLO;
            kla_pkg::ST_LR_MLO:
                state_next = kla_pkg::ST_LR_MHI;
            kla_pkg::ST_LR_MHI:
                state_next = kla_pkg::ST_LR_WR;
            kla_pkg::ST_LR_WR:
                state_next = comp_last ? kla_pkg::ST_OUT : kla_pkg::ST_LR_RDA;
            kla_pkg::ST_CP_RD:
                state_next = kla_pkg::ST_CP_WR;
            kla_pkg::ST_CP_WR:
                state_next = comp_last ? kla_pkg::ST_OUT : kla_pkg::ST_CP_RD;
            kla_pkg::ST_OUT:
                if (out_free)
                    state_next = kla_pkg::ST_IDLE;
            default:
                state_next = kla_pkg::ST_IDLE;
        endcase
    end

    // datapath controls
    always_comb
    begin
        req.ready    = 1'b0;
        time_rd_addr = key_idx_reg;
        time_wr_en   = 1'b0;
        comp_rd_addr = {key_idx_reg, comp_idx_reg};
        comp_wr_addr = {key_count_reg[KW-1:0], comp_idx_reg};
        comp_wr_en   = 1'b0;
        comp_wr_data = item_comp[comp_idx_reg];
        mul_a        = '0;
        mul_b        = '0;
        div_start    = 1'b0;
        case (state_reg)
            kla_pkg::ST_IDLE:
                req.ready = 1'b1;
            kla_pkg::ST_ADD_COMP:
            begin
                time_wr_en = comp_idx_reg == '0;
                comp_wr_en = !is_rot;
                mul_a      = kla_pkg::MUL_A_W'({1'b0, item_comp[comp_idx_reg][HALF_W-1:0]});
                mul_b      = kla_pkg::MUL_B_W'({1'b0, kla_pkg::DEG2RAD_Q32});
            end
            kla_pkg::ST_ADD_MHI:
            begin
                mul_a = {{2{item_comp[comp_idx_reg][31]}}, item_comp[comp_idx_reg][31:HALF_W]};
                mul_b = kla_pkg::MUL_B_W'({1'b0, kla_pkg::DEG2RAD_Q32});
            end
            kla_pkg::ST_ADD_WR:
            begin
                comp_wr_en   = 1'b1;
                comp_wr_data = acc_round[63:32];
            end
            kla_pkg::ST_PREV_RD:
                time_rd_addr = prev_idx;
            kla_pkg::ST_PREV_CHK:
                div_start = 1'b1;
            kla_pkg::ST_LR_RDA:
                comp_rd_addr = {prev_idx, comp_idx_reg};
            kla_pkg::ST_LR_MLO:
            begin
                mul_a = kla_pkg::MUL_A_W'({1'b0, d_reg[HALF_W-1:0]});
                mul_b = kla_pkg::MUL_B_W'({1'b0, t_reg});
            end
            kla_pkg::ST_LR_MHI:
            begin
                mul_a = {d_reg[32], d_reg[32:HALF_W]};
                mul_b = kla_pkg::MUL_B_W'({1'b0, t_reg});
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (time_wr_en)
            time_mem[key_count_reg[KW-1:0]] <= item_reg.time_value;
        time_rd_reg <= time_mem[time_rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (comp_wr_en)
            comp_mem[comp_wr_addr] <= comp_wr_data;
        comp_rd_reg <= comp_mem[comp_rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= kla_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            key_count_reg <= '0;
            elapsed_reg   <= '0;
            for (int i = 0; i < NCOMP; i++)
                frame_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid_reg && rsp.ready && state_reg != kla_pkg::ST_OUT)
                out_valid_reg <= 1'b0;
            case (state_reg)
                kla_pkg::ST_IDLE:
                    if (accept && kla_pkg::cmd_t'(req.data.cmd) == kla_pkg::CMD_CLEAR)
                    begin
                        key_count_reg <= '0;
                        elapsed_reg   <= '0;
                    end
                kla_pkg::ST_ADD_COMP:
                    if (!is_rot && comp_last)
                        key_count_reg <= key_count_reg + CW'(1);
                kla_pkg::ST_ADD_WR:
                    if (comp_last)
                        key_count_reg <= key_count_reg + CW'(1);
                kla_pkg::ST_LR_WR:
                    frame_reg[comp_idx_reg] <= lerp_val;
                kla_pkg::ST_CP_WR:
                    frame_reg[comp_idx_reg] <= comp_rd_reg;
                kla_pkg::ST_OUT:
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        if (finish_reg)
                        begin
                            key_count_reg <= '0;
                            elapsed_reg   <= '0;
                        end
                        else
                            elapsed_reg <= elapsed_sat;
                    end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            kla_pkg::ST_IDLE:
                if (accept)
                begin
                    item_reg     <= req.data;
                    comp_idx_reg <= '0;
                    key_idx_reg  <= '0;
                    finish_reg   <= key_count_reg == '0;
                end
            kla_pkg::ST_ADD_COMP:
                if (is_rot)
                    acc_reg <= ACC_W'(product);
                else
                    comp_idx_reg <= comp_idx_reg + CI_W'(1);
            kla_pkg::ST_ADD_MHI:
                acc_reg <= acc_reg + (ACC_W'(product) <<< HALF_W);
            kla_pkg::ST_ADD_WR:
                comp_idx_reg <= comp_idx_reg + CI_W'(1);
            kla_pkg::ST_SRCH_CHK:
                if (key_match)
                    key_time_reg <= time_rd_reg;
                else if (idx_last)
                    finish_reg <= 1'b1;
                else
                    key_idx_reg <= key_idx_reg + KW'(1);
            kla_pkg::ST_DIV:
                if (div_stat.done)
                    t_reg <= div_quot;
            kla_pkg::ST_LR_RDB:
                a_reg <= comp_rd_reg;
            kla_pkg::ST_LR_DIF:
                d_reg <= 33'(comp_rd_reg) - 33'(a_reg);
            kla_pkg::ST_LR_MLO:
                acc_reg <= ACC_W'(product);
            kla_pkg::ST_LR_MHI:
                acc_reg <= acc_reg + (ACC_W'(product) <<< HALF_W);
            kla_pkg::ST_LR_WR:
                comp_idx_reg <= comp_idx_reg + CI_W'(1);
            kla_pkg::ST_CP_WR:
                comp_idx_reg <= comp_idx_reg + CI_W'(1);
            kla_pkg::ST_OUT:
                if (out_free)
                begin
                    out_reg.finished    <= finish_reg;
                    out_reg.out_move_x  <= frame_reg[0];
                    out_reg.out_move_y  <= frame_reg[1];
                    out_reg.out_move_z  <= frame_reg[2];
                    out_reg.out_turn_x  <= frame_reg[3];
                    out_reg.out_turn_y  <= frame_reg[4];
                    out_reg.out_turn_z  <= frame_reg[5];
                    out_reg.out_size_x  <= frame_reg[6];
                    out_reg.out_size_y  <= frame_reg[7];
                    out_reg.out_size_z  <= frame_reg[8];
                    out_reg.out_opacity <= frame_reg[9];
                end
            default:
            begin
            end
        endcase
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_reg;

endmodule

### src/kla_div.sv
module kla_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [kla_pkg::TIME_W-1:0]  diff,
    input  logic [kla_pkg::TIME_W-1:0]  span,
    output kla_pkg::div_stat_t          stat,
    output logic [FRAC_BITS:0]          quot
);

    localparam int QW    = FRAC_BITS + 1;
    localparam int CNT_W = $clog2(FRAC_BITS + 1);

    logic                       busy_reg;
    logic                       done_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic [kla_pkg::TIME_W-1:0] rem_reg;
    logic [kla_pkg::TIME_W-1:0] span_reg;
    logic [QW-1:0]              quot_reg;
    logic [kla_pkg::TIME_W:0]   rem_sh;
    logic                       rem_ge;

    assign rem_sh = {rem_reg, 1'b0};
    assign rem_ge = rem_sh >= {1'b0, span_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(FRAC_BITS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // restoring division, one quotient bit per cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            span_reg <= span;
            if (diff >= span)
            begin
                rem_reg  <= diff - span;
                quot_reg <= QW'(1);
            end
            else
            begin
                rem_reg  <= diff;
                quot_reg <= '0;
            end
        end
        else if (busy_reg)
        begin
            if (rem_ge)
            begin
                rem_reg  <= kla_pkg::TIME_W'(rem_sh - {1'b0, span_reg});
                quot_reg <= {quot_reg[QW-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_sh[kla_pkg::TIME_W-1:0];
                quot_reg <= {quot_reg[QW-2:0], 1'b0};
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quot      = quot_reg;

endmodule
